>>> hdl/bahs_pkg.sv
`default_nettype none
package bahs_pkg;

    localparam int BUCKETS      = 1024;
    localparam int WAYS         = 4;
    localparam int ADDRESS_BITS = 48;

    // Width of the address field on the request channel.
    localparam int ADDR_W   = 48;
    // Bits of the address that take part in matching.
    localparam int KEY_W    = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
    // BUCKETS is a power of two, so the bucket is the low bits of the key.
    localparam int BUCKET_W = $clog2(BUCKETS);
    localparam int STATUS_W = 3;

    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [BUCKET_W-1:0] bucket_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_REMOVED  = 3'd2,
        ST_ABSENT   = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_DELETE = 1'b1
    } command_t;

    typedef enum logic [1:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_LOOKUP
    } fsm_t;

    // One memory row holds a whole bucket.
    typedef struct packed {
        logic [WAYS-1:0]            valid;
        logic [WAYS-1:0][KEY_W-1:0] key;
    } row_t;

    localparam int ROW_W = $bits(row_t);

endpackage
`default_nettype wire

>>> hdl/bahs_req_if.sv
`default_nettype none
interface bahs_req_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [bahs_pkg::ADDR_W-1:0] address;

    modport source (output valid, output command, output address, input ready);
    modport sink (input valid, input command, input address, output ready);
endinterface
`default_nettype wire

>>> hdl/bahs_rsp_if.sv
`default_nettype none
interface bahs_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bahs_pkg::STATUS_W-1:0] status;

    modport source (output valid, output status, input ready);
    modport sink (input valid, input status, output ready);
endinterface
`default_nettype wire

>>> hdl/bahs_ram.sv
`default_nettype none
module bahs_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

>>> hdl/bahs_bucket_eval.sv
`default_nettype none
module bahs_bucket_eval (
    input  wire logic           command,
    input  wire bahs_pkg::key_t key,
    input  wire bahs_pkg::row_t row,
    output bahs_pkg::status_t   status,
    output logic                wr_en,
    output bahs_pkg::row_t      row_next
);
    import bahs_pkg::*;

    logic [WAYS-1:0] match;
    logic [WAYS-1:0] free;
    logic [WAYS-1:0] first_free;
    logic            hit;

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            match[w] = row.valid[w] && (row.key[w] == key);
        end
    end

    assign free       = ~row.valid;
    // Isolate the lowest free way.
    assign first_free = free & (~free + WAYS'(1));
    assign hit        = |match;

    always_comb
    begin
        row_next = row;
        wr_en    = 1'b0;
        status   = ST_ABSENT;
        if (command == CMD_INSERT)
        begin
            if (hit)
            begin
                status = ST_PRESENT;
            end
            else if (|free)
            begin
                status         = ST_INSERTED;
                wr_en          = 1'b1;
                row_next.valid = row.valid | first_free;
                for (int w = 0; w < WAYS; w++)
                begin
                    if (first_free[w])
                    begin
                        row_next.key[w] = key;
                    end
                end
            end
            else
            begin
                status = ST_FULL;
            end
        end
        else
        begin
            if (hit)
            begin
                status         = ST_REMOVED;
                wr_en          = 1'b1;
                row_next.valid = row.valid & ~match;
            end
        end
    end

endmodule
`default_nettype wire

>>> hdl/breakpoint_address_hash_set_top.sv
// Breakpoint address set: a hash table of BUCKETS buckets with WAYS ways each.
// Request channel (req): command (0 insert, 1 delete) and a 48-bit address.
// Response channel (rsp): one status beat per request beat, in order:
// 0 inserted, 1 already present, 2 removed, 3 not present, 4 bucket full.
// The bucket is selected by the low address bits.
// Each request is handled in the IDLE and LOOKUP states: in IDLE the beat is
// accepted and its bucket row is read from the table memory; in LOOKUP the
// row is checked, written back if it changes, and the status is loaded into
// the response register, which offers the status beat on rsp.
// The table memory read is registered, and no new request is accepted until
// the lookup of the previous one has finished and written back.
// After reset the block sweeps the table once, one bucket a cycle, clearing
// all valid bits: req.ready stays low until the sweep is done.
// A new request is accepted while an earlier status still waits on rsp. If
// the receiver stalls, the finished lookup holds its read data and waits
// until the response register is free; no request is accepted meanwhile.
`default_nettype none
module breakpoint_address_hash_set_top (
    input  wire logic clk,
    input  wire logic rst_n,
    bahs_req_if.sink  req,
    bahs_rsp_if.source rsp
);
    import bahs_pkg::*;

    fsm_t     state_reg, state_next;
    bucket_t  clr_idx_reg, clr_idx_next;
    logic     cmd_reg;
    key_t     key_reg;
    status_t  status_reg;
    logic     rsp_valid_reg, rsp_valid_next;

    key_t     req_key;
    logic     mem_wr_en;
    bucket_t  mem_wr_addr;
    row_t     mem_wr_row;
    logic     mem_rd_en;
    logic [ROW_W-1:0] mem_rd_data;
    row_t     rd_row;

    status_t  eval_status;
    logic     eval_wr_en;
    row_t     eval_row;

    logic     accept;
    logic     finish;

    assign req_key = req.address[KEY_W-1:0];
    assign rd_row  = row_t'(mem_rd_data);

    bahs_ram #(
        .DEPTH(BUCKETS),
        .WIDTH(ROW_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_row),
        .rd_en   (mem_rd_en),
        .rd_addr (req_key[BUCKET_W-1:0]),
        .rd_data (mem_rd_data)
    );

    bahs_bucket_eval u_eval (
        .command  (cmd_reg),
        .key      (key_reg),
        .row      (rd_row),
        .status   (eval_status),
        .wr_en    (eval_wr_en),
        .row_next (eval_row)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_CLEAR;
            clr_idx_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= req.command;
            key_reg <= req_key;
        end
        if (finish)
        begin
            status_reg <= eval_status;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        req.ready    = 1'b0;
        accept       = 1'b0;
        finish       = 1'b0;
        mem_rd_en    = 1'b0;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = clr_idx_reg;
        mem_wr_row   = '0;
        unique case (state_reg)
            FSM_CLEAR:
            begin
                mem_wr_en    = 1'b1;
                clr_idx_next = clr_idx_reg + BUCKET_W'(1);
                if (clr_idx_reg == BUCKET_W'(BUCKETS - 1))
                begin
                    state_next = FSM_IDLE;
                end
            end
            FSM_IDLE:
            begin
                req.ready = 1'b1;
                accept    = req.valid;
                mem_rd_en = req.valid;
                if (req.valid)
                begin
                    state_next = FSM_LOOKUP;
                end
            end
            FSM_LOOKUP:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    finish      = 1'b1;
                    mem_wr_en   = eval_wr_en;
                    mem_wr_addr = key_reg[BUCKET_W-1:0];
                    mem_wr_row  = eval_row;
                    state_next  = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (finish)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.status = status_reg;

endmodule
`default_nettype wire
